// ----- hdl/rmq_pkg.sv -----
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, types and constants of the matrix-to-quaternion converter.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS = 14;
    localparam int CELL_W    = 16;
    localparam int ARG_W     = CELL_W + 2;           // one + three diagonals
    localparam int NUM_W     = CELL_W + 1;           // sum or difference of two cells
    localparam int SQ_SHIFT  = FRAC_BITS - 2;
    localparam int RAD_W     = 30;                   // even, holds arg << SQ_SHIFT
    localparam int ROOT_W    = RAD_W / 2;
    localparam int REM_W     = ROOT_W + 2;
    localparam int SQ_LAT    = ROOT_W;               // one root bit per stage
    localparam int DV_BITS   = 16;                   // quotient bits before saturation
    localparam int DV_LAT    = DV_BITS + 1;          // prep stage plus one bit per stage
    localparam int DIVD_W    = NUM_W + FRAC_BITS - 2;
    localparam int CMP_W     = ROOT_W + DV_BITS;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch                   br;
        logic                      fault;
        logic signed [NUM_W-1:0]   num0;
        logic signed [NUM_W-1:0]   num1;
        logic signed [NUM_W-1:0]   num2;
    } t_side;

endpackage

// ----- hdl/rmq_sqrt.sv -----
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined integer square root, one root bit per stage, with sideband.
// ----------------------------------------------------------------------------
module rmq_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  logic [rmq_pkg::RAD_W-1:0]   i_rad,
    input  rmq_pkg::t_side              i_side,
    output logic                        o_vld,
    output logic [rmq_pkg::ROOT_W-1:0]  o_root,
    output rmq_pkg::t_side              o_side
);
    import rmq_pkg::*;

    logic              r_vld  [SQ_LAT];
    logic [RAD_W-1:0]  r_x    [SQ_LAT];
    logic [REM_W-1:0]  r_rem  [SQ_LAT];
    logic [ROOT_W-1:0] r_root [SQ_LAT];
    t_side             r_side [SQ_LAT];

    logic              s_vld  [SQ_LAT];
    logic [RAD_W-1:0]  s_x    [SQ_LAT];
    logic [REM_W-1:0]  s_rem  [SQ_LAT];
    logic [ROOT_W-1:0] s_root [SQ_LAT];
    t_side             s_side [SQ_LAT];

    logic [RAD_W-1:0]  n_x    [SQ_LAT];
    logic [REM_W-1:0]  n_rem  [SQ_LAT];
    logic [ROOT_W-1:0] n_root [SQ_LAT];

    logic [REM_W+1:0]  t_val  [SQ_LAT];
    logic [REM_W+1:0]  t_try  [SQ_LAT];

    always_comb begin
        for (int k = 0; k < SQ_LAT; k++) begin
            if (k == 0) begin
                s_vld[k]  = i_vld;
                s_x[k]    = i_rad;
                s_rem[k]  = '0;
                s_root[k] = '0;
                s_side[k] = i_side;
            end else begin
                s_vld[k]  = r_vld[k-1];
                s_x[k]    = r_x[k-1];
                s_rem[k]  = r_rem[k-1];
                s_root[k] = r_root[k-1];
                s_side[k] = r_side[k-1];
            end
            t_val[k] = {s_rem[k], s_x[k][RAD_W-1 -: 2]};
            t_try[k] = (REM_W+2)'({s_root[k], 2'b01});
            n_x[k]   = {s_x[k][RAD_W-3:0], 2'b00};
            if (t_val[k] >= t_try[k]) begin
                n_rem[k]  = REM_W'(t_val[k] - t_try[k]);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = REM_W'(t_val[k]);
                n_root[k] = {s_root[k][ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < SQ_LAT; k++) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= s_vld[k];
            end
            if (i_en) begin
                r_x[k]    <= n_x[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
                r_side[k] <= s_side[k];
            end
        end
    end

    assign o_vld  = r_vld[SQ_LAT-1];
    assign o_root = r_root[SQ_LAT-1];
    assign o_side = r_side[SQ_LAT-1];

endmodule

// ----- hdl/rmq_div.sv -----
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined signed divide of num * 2^(FRAC_BITS-2) by the pivot, truncated
// toward zero and saturated to 16 bits.
// ----------------------------------------------------------------------------
module rmq_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [rmq_pkg::NUM_W-1:0]   i_num,
    input  logic [rmq_pkg::ROOT_W-1:0]         i_piv,
    output logic signed [rmq_pkg::CELL_W-1:0]  o_q
);
    import rmq_pkg::*;

    logic [DIVD_W-1:0]  r_rem [DV_LAT];
    logic [DV_BITS-1:0] r_q   [DV_LAT];
    logic [ROOT_W-1:0]  r_piv [DV_LAT];
    logic               r_neg [DV_LAT];
    logic               r_ovf [DV_LAT];

    logic [NUM_W-1:0]   p_mag;
    logic [DIVD_W-1:0]  p_divd;
    logic [DIVD_W-1:0]  n_rem [DV_LAT];
    logic [DV_BITS-1:0] n_q   [DV_LAT];
    logic [CMP_W-1:0]   c_sub [DV_LAT];
    logic [DV_BITS:0]   q_ext;

    assign p_mag  = i_num[NUM_W-1] ? NUM_W'(-i_num) : NUM_W'(i_num);
    assign p_divd = DIVD_W'(p_mag) << SQ_SHIFT;

    always_comb begin
        n_rem[0] = p_divd;
        n_q[0]   = '0;
        c_sub[0] = '0;
        for (int k = 1; k < DV_LAT; k++) begin
            c_sub[k] = CMP_W'(r_piv[k-1]) << (DV_BITS - k);
            if (CMP_W'(r_rem[k-1]) >= c_sub[k]) begin
                n_rem[k] = DIVD_W'(CMP_W'(r_rem[k-1]) - c_sub[k]);
                n_q[k]   = r_q[k-1] | (DV_BITS'(1) << (DV_BITS - k));
            end else begin
                n_rem[k] = r_rem[k-1];
                n_q[k]   = r_q[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_piv[0] <= i_piv;
            r_neg[0] <= i_num[NUM_W-1];
            // quotient of 2^DV_BITS or more saturates anyway
            r_ovf[0] <= (CMP_W'(p_divd) >= (CMP_W'(i_piv) << DV_BITS));
            for (int k = 1; k < DV_LAT; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_piv[k] <= r_piv[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    assign q_ext = {1'b0, r_q[DV_LAT-1]};

    always_comb begin
        if (r_neg[DV_LAT-1]) begin
            if (r_ovf[DV_LAT-1] || q_ext > (DV_BITS+1)'(32768)) begin
                o_q = -16'sd32768;
            end else begin
                o_q = CELL_W'(-q_ext);
            end
        end else begin
            if (r_ovf[DV_LAT-1] || q_ext > (DV_BITS+1)'(32767)) begin
                o_q = 16'sd32767;
            end else begin
                o_q = CELL_W'(q_ext);
            end
        end
    end

endmodule

// ----- hdl/rotation_matrix_to_quaternion_unit.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit
// Converts the 3x3 rotation part of a matrix (Q2.14) to a quaternion (Q2.14).
// ----------------------------------------------------------------------------
// Input channel: nine matrix cells with i_valid / o_stall; a request is taken
// on a clock edge with i_valid high and o_stall low.
// Output channel: quaternion, branch code and fault flag with o_valid /
// i_stall; a result is taken on an edge with o_valid high and i_stall low.
// Throughput: one request per cycle unless the receiver stalls. Pipeline:
// one decode stage, 15 square-root stages (one root bit each), 17 divider
// stages (operand prep plus one quotient bit each) and the output register.
// When the receiver stalls a valid result, the whole pipeline holds and
// o_stall rises; no request is lost or repeated.
// Reset clears all valid bits; the pipeline is empty and ready afterwards.
// A non-positive square-root argument sets o_sqrt_fault and zeroes the
// quaternion; o_branch_taken still shows the selected branch.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_0,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_1,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_2,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_4,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_5,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_6,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_8,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_9,
    input  logic signed [rmq_pkg::CELL_W-1:0]  i_cell_10,
    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [rmq_pkg::CELL_W-1:0]  o_quat_x,
    output logic signed [rmq_pkg::CELL_W-1:0]  o_quat_y,
    output logic signed [rmq_pkg::CELL_W-1:0]  o_quat_z,
    output logic signed [rmq_pkg::CELL_W-1:0]  o_quat_w,
    output logic [1:0]                         o_branch_taken,
    output logic                               o_sqrt_fault
);
    import rmq_pkg::*;

    logic en;

    // decode
    logic signed [ARG_W-1:0] d_c0, d_c5, d_c10, d_trace, d_arg;
    logic signed [NUM_W-1:0] d_a, d_b, d_c, d_d, d_e, d_f;
    t_branch                 d_br;
    t_side                   d_side;

    logic                    r_dec_vld;
    logic [RAD_W-1:0]        r_dec_rad;
    t_side                   r_dec_side;

    logic                    sq_vld;
    logic [ROOT_W-1:0]       sq_root;
    t_side                   sq_side;

    logic                    r_dv_vld  [DV_LAT];
    logic [ROOT_W-1:0]       r_dv_piv  [DV_LAT];
    t_side                   r_dv_side [DV_LAT];

    logic signed [CELL_W-1:0] dv_q0, dv_q1, dv_q2, piv_s;

    logic                     r_out_vld;
    logic signed [CELL_W-1:0] r_qx, r_qy, r_qz, r_qw;
    t_branch                  r_br;
    logic                     r_fault;
    logic signed [CELL_W-1:0] n_qx, n_qy, n_qz, n_qw;

    assign o_stall = r_out_vld && i_stall;
    assign en      = !o_stall;

    assign d_c0    = ARG_W'(i_cell_0);
    assign d_c5    = ARG_W'(i_cell_5);
    assign d_c10   = ARG_W'(i_cell_10);
    assign d_trace = d_c0 + d_c5 + d_c10;

    assign d_a = NUM_W'(i_cell_6) - NUM_W'(i_cell_9);   // m6 - m9
    assign d_b = NUM_W'(i_cell_8) - NUM_W'(i_cell_2);   // m8 - m2
    assign d_c = NUM_W'(i_cell_1) - NUM_W'(i_cell_4);   // m1 - m4
    assign d_d = NUM_W'(i_cell_4) + NUM_W'(i_cell_1);   // m4 + m1
    assign d_e = NUM_W'(i_cell_8) + NUM_W'(i_cell_2);   // m8 + m2
    assign d_f = NUM_W'(i_cell_9) + NUM_W'(i_cell_6);   // m9 + m6

    always_comb begin
        priority if (d_trace > 0) begin
            d_br  = BR_W;
            d_arg = d_trace + ARG_W'(1 << FRAC_BITS);
        end else if (i_cell_0 > i_cell_5 && i_cell_0 > i_cell_10) begin
            d_br  = BR_X;
            d_arg = ARG_W'(1 << FRAC_BITS) + d_c0 - d_c5 - d_c10;
        end else if (i_cell_5 > i_cell_10) begin
            d_br  = BR_Y;
            d_arg = ARG_W'(1 << FRAC_BITS) + d_c5 - d_c0 - d_c10;
        end else begin
            d_br  = BR_Z;
            d_arg = ARG_W'(1 << FRAC_BITS) + d_c10 - d_c0 - d_c5;
        end
    end

    // lanes hold the three non-pivot components in x, y, z, w order
    always_comb begin
        d_side.br    = d_br;
        d_side.fault = (d_arg <= 0);
        unique case (d_br)
            BR_W: begin
                d_side.num0 = d_a;
                d_side.num1 = d_b;
                d_side.num2 = d_c;
            end
            BR_X: begin
                d_side.num0 = d_d;
                d_side.num1 = d_e;
                d_side.num2 = d_a;
            end
            BR_Y: begin
                d_side.num0 = d_d;
                d_side.num1 = d_f;
                d_side.num2 = d_b;
            end
            BR_Z: begin
                d_side.num0 = d_e;
                d_side.num1 = d_f;
                d_side.num2 = d_c;
            end
            default: begin
                d_side.num0 = d_a;
                d_side.num1 = d_b;
                d_side.num2 = d_c;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dec_vld <= 1'b0;
        end else if (en) begin
            r_dec_vld <= i_valid;
        end
        if (en) begin
            r_dec_rad  <= RAD_W'(d_arg[ARG_W-2:0]) << SQ_SHIFT;
            r_dec_side <= d_side;
        end
    end

    rmq_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_dec_vld),
        .i_rad   (r_dec_rad),
        .i_side  (r_dec_side),
        .o_vld   (sq_vld),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    rmq_div u_div0 (.i_clk(i_clk), .i_en(en), .i_num(sq_side.num0), .i_piv(sq_root),
                    .o_q(dv_q0));
    rmq_div u_div1 (.i_clk(i_clk), .i_en(en), .i_num(sq_side.num1), .i_piv(sq_root),
                    .o_q(dv_q1));
    rmq_div u_div2 (.i_clk(i_clk), .i_en(en), .i_num(sq_side.num2), .i_piv(sq_root),
                    .o_q(dv_q2));

    // advance valid, pivot and sideband (branch, fault flag) alongside the dividers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DV_LAT; k++) begin
            if (!i_rst_n) begin
                r_dv_vld[k] <= 1'b0;
            end else if (en) begin
                r_dv_vld[k] <= (k == 0) ? sq_vld : r_dv_vld[k-1];
            end
            if (en) begin
                r_dv_piv[k]  <= (k == 0) ? sq_root : r_dv_piv[k-1];
                r_dv_side[k] <= (k == 0) ? sq_side : r_dv_side[k-1];
            end
        end
    end

    assign piv_s = CELL_W'(r_dv_piv[DV_LAT-1]);

    always_comb begin
        n_qx = '0;
        n_qy = '0;
        n_qz = '0;
        n_qw = '0;
        if (!r_dv_side[DV_LAT-1].fault) begin
            unique case (r_dv_side[DV_LAT-1].br)
                BR_W: begin
                    n_qx = dv_q0; n_qy = dv_q1; n_qz = dv_q2; n_qw = piv_s;
                end
                BR_X: begin
                    n_qx = piv_s; n_qy = dv_q0; n_qz = dv_q1; n_qw = dv_q2;
                end
                BR_Y: begin
                    n_qx = dv_q0; n_qy = piv_s; n_qz = dv_q1; n_qw = dv_q2;
                end
                BR_Z: begin
                    n_qx = dv_q0; n_qy = dv_q1; n_qz = piv_s; n_qw = dv_q2;
                end
                default: begin
                    n_qx = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_dv_vld[DV_LAT-1];
        end
        if (en) begin
            r_qx    <= n_qx;
            r_qy    <= n_qy;
            r_qz    <= n_qz;
            r_qw    <= n_qw;
            r_br    <= r_dv_side[DV_LAT-1].br;
            r_fault <= r_dv_side[DV_LAT-1].fault;
        end
    end

    assign o_valid        = r_out_vld;
    assign o_quat_x       = r_qx;
    assign o_quat_y       = r_qy;
    assign o_quat_z       = r_qz;
    assign o_quat_w       = r_qw;
    assign o_branch_taken = r_br;
    assign o_sqrt_fault   = r_fault;

`ifndef SYNTHESIS
    a_fault_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_sqrt_fault |->
            o_quat_x == 0 && o_quat_y == 0 && o_quat_z == 0 && o_quat_w == 0)
        else $error("fault result carries nonzero quaternion");

    a_pivot_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_sqrt_fault |->
            (o_branch_taken == BR_W && o_quat_w > 0) ||
            (o_branch_taken == BR_X && o_quat_x > 0) ||
            (o_branch_taken == BR_Y && o_quat_y > 0) ||
            (o_branch_taken == BR_Z && o_quat_z > 0))
        else $error("pivot component not positive");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r_dv_vld[DV_LAT-1]) && $stable(r_dec_vld))
        else $error("pipeline advanced during stall");
`endif

endmodule

// ----- bench/rotation_matrix_to_quaternion_unit_tb.sv -----
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_unit_tb
// Streams rotation and non-rotation matrices through the converter, predicts
// each quaternion, branch code and fault flag in integer arithmetic, and
// compares every result in order under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_unit_tb;
    import rmq_pkg::*;

    typedef logic signed [CELL_W-1:0] t_cell;

    typedef struct packed {
        t_cell m0, m1, m2, m4, m5, m6, m8, m9, m10;
    } t_matrix;

    typedef struct packed {
        t_cell   qx, qy, qz, qw;
        t_branch br;
        logic    fault;
    } t_quat;

    localparam int LATENCY   = 34;
    localparam int WDOG_MAX  = 20000;
    localparam int LONG_HOLD = 300;

    logic    clk, rst_n;
    logic    in_valid, out_stall_dut, out_valid, rx_stall;
    t_matrix drv;
    t_cell   qx, qy, qz, qw;
    logic [1:0] br_out;
    logic    fault_out;

    t_matrix pending_mats[$];
    t_quat   expected_quats[$];
    int      mismatches, results_seen, faults_seen, wdog;
    int      branch_hits[4];
    int      tx_idle_pct, rx_stall_pct;
    bit      hold_rx, in_taken;

    rotation_matrix_to_quaternion_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(out_stall_dut),
        .i_cell_0(drv.m0), .i_cell_1(drv.m1), .i_cell_2(drv.m2),
        .i_cell_4(drv.m4), .i_cell_5(drv.m5), .i_cell_6(drv.m6),
        .i_cell_8(drv.m8), .i_cell_9(drv.m9), .i_cell_10(drv.m10),
        .o_valid(out_valid), .i_stall(rx_stall),
        .o_quat_x(qx), .o_quat_y(qy), .o_quat_z(qz), .o_quat_w(qw),
        .o_branch_taken(br_out), .o_sqrt_fault(fault_out)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint isqrt(longint n);
        longint r, b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > n) b = b >>> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic t_cell clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return t_cell'(v);
    endfunction

    // SV division truncates toward zero, as required
    function automatic t_cell scaled_quot(longint num, longint s);
        return clamp16((num * (64'sd1 <<< FRAC_BITS)) / s);
    endfunction

    function automatic t_quat matrix_to_quat(t_matrix m);
        t_quat  q;
        longint a0, a1, a2, a4, a5, a6, a8, a9, a10, tr, arg, piv, s;
        a0 = m.m0; a1 = m.m1; a2 = m.m2; a4 = m.m4; a5 = m.m5;
        a6 = m.m6; a8 = m.m8; a9 = m.m9; a10 = m.m10;
        q = '0;
        tr = a0 + a5 + a10;
        if (tr > 0) begin
            q.br = BR_W; arg = tr + (64'sd1 <<< FRAC_BITS);
        end else if (a0 > a5 && a0 > a10) begin
            q.br = BR_X; arg = (64'sd1 <<< FRAC_BITS) + a0 - a5 - a10;
        end else if (a5 > a10) begin
            q.br = BR_Y; arg = (64'sd1 <<< FRAC_BITS) + a5 - a0 - a10;
        end else begin
            q.br = BR_Z; arg = (64'sd1 <<< FRAC_BITS) + a10 - a0 - a5;
        end
        if (arg <= 0) begin
            q.fault = 1'b1;
            return q;
        end
        piv = isqrt(arg <<< (FRAC_BITS - 2));
        s = 4 * piv;
        case (q.br)
            BR_W: begin
                q.qw = clamp16(piv);
                q.qx = scaled_quot(a6 - a9, s);
                q.qy = scaled_quot(a8 - a2, s);
                q.qz = scaled_quot(a1 - a4, s);
            end
            BR_X: begin
                q.qx = clamp16(piv);
                q.qw = scaled_quot(a6 - a9, s);
                q.qy = scaled_quot(a4 + a1, s);
                q.qz = scaled_quot(a8 + a2, s);
            end
            BR_Y: begin
                q.qy = clamp16(piv);
                q.qw = scaled_quot(a8 - a2, s);
                q.qx = scaled_quot(a4 + a1, s);
                q.qz = scaled_quot(a9 + a6, s);
            end
            default: begin
                q.qz = clamp16(piv);
                q.qw = scaled_quot(a1 - a4, s);
                q.qx = scaled_quot(a8 + a2, s);
                q.qy = scaled_quot(a9 + a6, s);
            end
        endcase
        return q;
    endfunction

    function automatic t_cell rnd_cell();
        return t_cell'($urandom_range(65535, 0));
    endfunction

    // near-rotation: one diagonal raised as pivot unless k is 0, off-diagonals within +-1.0
    function automatic t_matrix rnd_rotation();
        t_matrix m;
        int      k;
        m = '0;
        k = $urandom_range(3, 0);
        m.m1 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m2 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m4 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m6 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m8 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m9 = t_cell'($signed($urandom_range(32767, 0)) - 16384);
        m.m0 = t_cell'($signed($urandom_range(16384, 0)) - 12000);
        m.m5 = t_cell'($signed($urandom_range(16384, 0)) - 12000);
        m.m10 = t_cell'($signed($urandom_range(16384, 0)) - 12000);
        case (k)
            1: m.m0 = t_cell'($urandom_range(16384, 4000));
            2: m.m5 = t_cell'($urandom_range(16384, 4000));
            3: m.m10 = t_cell'($urandom_range(16384, 4000));
            default: ;
        endcase
        return m;
    endfunction

    function automatic t_matrix rnd_any();
        t_matrix m;
        m.m0 = rnd_cell(); m.m1 = rnd_cell(); m.m2 = rnd_cell();
        m.m4 = rnd_cell(); m.m5 = rnd_cell(); m.m6 = rnd_cell();
        m.m8 = rnd_cell(); m.m9 = rnd_cell(); m.m10 = rnd_cell();
        return m;
    endfunction

    function automatic t_matrix diag(int d0, int d5, int d10, int off);
        t_matrix m;
        m.m0 = t_cell'(d0); m.m5 = t_cell'(d5); m.m10 = t_cell'(d10);
        m.m1 = t_cell'(off); m.m2 = t_cell'(-off); m.m4 = t_cell'(-off);
        m.m6 = t_cell'(off); m.m8 = t_cell'(off); m.m9 = t_cell'(-off);
        return m;
    endfunction

    // driver: hold payload until taken, advance once the request is accepted
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_taken) begin
            if (pending_mats.size() > 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                drv      <= pending_mats.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
        rx_stall <= hold_rx || ($urandom_range(99, 0) < rx_stall_pct);
    end

    // monitor
    always @(posedge clk) begin
        t_quat exp_q;
        bit    moved;
        moved = 1'b0;
        if (rst_n) begin
            in_taken <= in_valid && !out_stall_dut;
            if (in_valid && !out_stall_dut) begin
                expected_quats.push_back(matrix_to_quat(drv));
                moved = 1'b1;
            end
            if (out_valid && !rx_stall) begin
                moved = 1'b1;
                results_seen <= results_seen + 1;
                if (expected_quats.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result at %0t", $time);
                end else begin
                    exp_q = expected_quats.pop_front();
                    branch_hits[exp_q.br] <= branch_hits[exp_q.br] + 1;
                    if (exp_q.fault) faults_seen <= faults_seen + 1;
                    if (qx !== exp_q.qx || qy !== exp_q.qy || qz !== exp_q.qz ||
                        qw !== exp_q.qw || br_out !== exp_q.br ||
                        fault_out !== exp_q.fault) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10) begin
                            $display("mismatch at %0t: exp x=%0d y=%0d z=%0d w=%0d br=%0d f=%0b",
                                $time, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.qw, exp_q.br,
                                exp_q.fault);
                            $display("    got x=%0d y=%0d z=%0d w=%0d br=%0d f=%0b",
                                qx, qy, qz, qw, br_out, fault_out);
                        end
                    end
                end
            end
            wdog <= moved ? 0 : wdog + 1;
            if (wdog >= WDOG_MAX) begin
                $display("watchdog expired at %0t", $time);
                $display("RESULT: ERROR");
                $finish;
            end
        end else begin
            in_taken <= 1'b0;
        end
    end

    task automatic drain();
        while (pending_mats.size() > 0 || in_valid || expected_quats.size() > 0)
            @(posedge clk);
    endtask

    initial begin
        int idle_tx[5], idle_rx[5];
        idle_tx = '{0, 87, 0, 36, 0};
        idle_rx = '{0, 0, 87, 36, 0};
        rst_n = 1'b0; in_valid = 1'b0; rx_stall = 1'b0; hold_rx = 1'b0;
        drv = '0; mismatches = 0; results_seen = 0; faults_seen = 0; wdog = 0;
        branch_hits = '{0, 0, 0, 0};
        tx_idle_pct = 0; rx_stall_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: identity, each pivot, ties, extremes
        pending_mats.push_back(diag(16384, 16384, 16384, 0));
        pending_mats.push_back(diag(16384, -16384, -16384, 0));
        pending_mats.push_back(diag(-16384, 16384, -16384, 0));
        pending_mats.push_back(diag(-16384, -16384, 16384, 0));
        pending_mats.push_back(diag(0, 0, 0, 1000));
        pending_mats.push_back(diag(-5000, -5000, -5000, 2000));
        pending_mats.push_back(diag(-8000, -3000, -3000, 3000));
        pending_mats.push_back(diag(1, 0, -1, 0));
        pending_mats.push_back(diag(0, 1, 0, 0));
        pending_mats.push_back(diag(-32768, -32768, -32768, 0));
        pending_mats.push_back(diag(32767, 32767, 32767, 32767));
        pending_mats.push_back(diag(32767, -32768, -32768, -32768));
        pending_mats.push_back(diag(-32768, 32767, -32768, 32767));
        pending_mats.push_back(diag(-32768, -32768, 32767, -32768));
        pending_mats.push_back(diag(-10000, -10000, -32768, 5000));
        pending_mats.push_back(diag(-32768, -20000, 12000, -1));
        pending_mats.push_back(diag(-16384, -16384, -16384, 32767));
        pending_mats.push_back(diag(-100, -100, -100, -32768));
        pending_mats.push_back(diag(1, 1, -2, 77));
        pending_mats.push_back(diag(-1, -32768, -32768, 32767));

        for (int ph = 0; ph < 5; ph++) begin
            tx_idle_pct = idle_tx[ph];
            rx_stall_pct = idle_rx[ph];
            for (int i = 0; i < 100; i++)
                pending_mats.push_back(($urandom_range(3, 0) != 0) ? rnd_rotation() : rnd_any());
            if (ph == 4) begin
                // hold off the receiver so the pipeline fills and stalls its input
                hold_rx = 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                hold_rx = 1'b0;
            end
            drain();
        end
        repeat (LATENCY + 10) @(posedge clk);

        $display("covered %0d results: branches w/x/y/z %0d/%0d/%0d/%0d, %0d faults",
            results_seen, branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3],
            faults_seen);
        $display("idle phases none, sender, receiver, both and one long receiver hold");
        if (mismatches == 0 && expected_quats.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches,
                expected_quats.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
